// ===== src/strd_pkg.sv =====
// Shared types and constants for the signed integer to radix text converter.
package strd_pkg;

    localparam int MAX_RADIX_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int RADIX_W = 5;
    localparam int SYM_W   = 8;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 2;
    localparam int STEPS   = 8;

    localparam logic [IDX_W-1:0] REG_RADIX   = 2'd0;
    localparam logic [IDX_W-1:0] REG_SYM_LO  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYM_HI  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
    localparam logic [CFG_W-1:0]   SYM_LO_RESET = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   SYM_HI_RESET = 64'h0000_0000_0000_3938;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_LOW   = 8'd32;
    localparam logic [SYM_W-1:0] CHAR_HIGH  = 8'd126;

    typedef enum logic [1:0] {
        EMIT_ERR   = 2'd0,
        EMIT_MINUS = 2'd1,
        EMIT_DIGIT = 2'd2
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  push;
        logic  emit;
        t_emit emit_kind;
    } t_cmd;

    typedef struct packed {
        logic alpha_ok;
        logic neg;
        logic pass_last;
        logic quot_zero;
        logic slot_free;
        logic last_digit;
    } t_status;

endpackage

// ===== src/strd_ctrl.sv =====
// Sequencing state machine for the radix conversion.
module strd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  strd_pkg::t_status i_status,
    output strd_pkg::t_cmd    o_cmd
);
    import strd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SIGN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_PUSH  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.push      = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_kind = EMIT_DIGIT;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.alpha_ok) begin
                    if (i_status.slot_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = EMIT_ERR;
                        n_state         = S_IDLE;
                    end
                end else if (i_status.neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_SIGN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_MINUS;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.pass_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_status.quot_zero ? S_EMIT : S_DIV;
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_DIGIT;
                    if (i_status.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/strd_dpath.sv =====
// Datapath: configuration, alphabet check, digit divider, digit stack and output register.
module strd_dpath #(
    parameter int MAX_RADIX  = strd_pkg::MAX_RADIX_DEF,
    parameter int VALUE_BITS = strd_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [strd_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [strd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic signed [VALUE_BITS-1:0]   i_value,
    input  strd_pkg::t_cmd                 i_cmd,
    output strd_pkg::t_status              o_status,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [strd_pkg::SYM_W-1:0]     o_symbol,
    output logic                           o_is_last,
    output logic                           o_status_bit
);
    import strd_pkg::*;

    localparam int PASSES = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int PAD_W  = PASSES * STEPS;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int DIG_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int DEPTH  = VALUE_BITS;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Configuration registers.
    logic [RADIX_W-1:0] r_radix;
    logic [CFG_W-1:0]   r_sym_lo;
    logic [CFG_W-1:0]   r_sym_hi;
    logic [2*CFG_W-1:0] symbols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RESET;
            r_sym_lo <= SYM_LO_RESET;
            r_sym_hi <= SYM_HI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIX:  r_radix  <= i_cfg_data[RADIX_W-1:0];
                REG_SYM_LO: r_sym_lo <= i_cfg_data;
                REG_SYM_HI: r_sym_hi <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign symbols = {r_sym_hi, r_sym_lo};

    // Alphabet check over the symbols in use, all comparisons in parallel.
    logic alpha_ok;
    logic [SYM_W-1:0] ci;

    always_comb begin
        alpha_ok = (r_radix >= RADIX_W'(2)) && (r_radix <= RADIX_W'(MAX_RADIX));
        ci       = '0;
        for (int i = 0; i < MAX_RADIX; i++) begin
            ci = symbols[i*SYM_W +: SYM_W];
            if (RADIX_W'(i) < r_radix) begin
                if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci < CHAR_LOW || ci > CHAR_HIGH) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (RADIX_W'(j) < r_radix && symbols[j*SYM_W +: SYM_W] == ci) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Divider: the remainder stays below the radix, so each step is a narrow
    // compare and subtract; STEPS quotient bits are produced per cycle.
    logic                  r_neg;
    logic [PAD_W-1:0]      r_quot;
    logic [DIG_W-1:0]      r_rem;
    logic [PASS_W-1:0]     r_pass;
    logic [VALUE_BITS-1:0] mag;
    logic [PAD_W-1:0]      n_quot;
    logic [DIG_W-1:0]      n_rem;
    logic [RADIX_W:0]      part;
    logic [RADIX_W:0]      diff;

    assign mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        part   = '0;
        diff   = '0;
        for (int s = 0; s < STEPS; s++) begin
            part = (RADIX_W + 1)'({n_rem, n_quot[PAD_W-1]});
            diff = part - {1'b0, r_radix};
            if (part >= {1'b0, r_radix}) begin
                n_rem  = diff[DIG_W-1:0];
                n_quot = {n_quot[PAD_W-2:0], 1'b1};
            end else begin
                n_rem  = part[DIG_W-1:0];
                n_quot = {n_quot[PAD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[VALUE_BITS-1];
            r_quot <= PAD_W'(mag);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end else if (i_cmd.push) begin
            r_rem  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
        end else if (i_cmd.load || i_cmd.push) begin
            r_pass <= '0;
        end else if (i_cmd.div_step) begin
            r_pass <= r_pass + 1'b1;
        end
    end

    // Digit stack: least significant digit pushed first, popped from the top.
    logic [DIG_W-1:0] r_stack [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign pop = i_cmd.emit && (i_cmd.emit_kind == EMIT_DIGIT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[0] <= r_rem;
            for (int k = 1; k < DEPTH; k++) begin
                r_stack[k] <= r_stack[k-1];
            end
        end else if (pop) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                r_stack[k] <= r_stack[k+1];
            end
            r_stack[DEPTH-1] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + 1'b1;
        end else if (pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Output register; a new result may be loaded as the held one transfers.
    logic             r_valid;
    logic [SYM_W-1:0] r_symbol;
    logic             r_is_last;
    logic             r_err;
    logic             slot_free;
    logic [SYM_W-1:0] top_sym;

    assign slot_free = !r_valid || i_ready;
    assign top_sym   = symbols[{4'(r_stack[0]), 3'b000} +: SYM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.emit_kind)
                EMIT_ERR: begin
                    r_symbol  <= '0;
                    r_is_last <= 1'b1;
                    r_err     <= 1'b1;
                end
                EMIT_MINUS: begin
                    r_symbol  <= CHAR_MINUS;
                    r_is_last <= 1'b0;
                    r_err     <= 1'b0;
                end
                default: begin
                    r_symbol  <= top_sym;
                    r_is_last <= (r_count == CNT_W'(1));
                    r_err     <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_symbol     = r_symbol;
    assign o_is_last    = r_is_last;
    assign o_status_bit = r_err;

    assign o_status.alpha_ok   = alpha_ok;
    assign o_status.neg        = r_neg;
    assign o_status.pass_last  = (r_pass == PASS_W'(PASSES - 1));
    assign o_status.quot_zero  = (r_quot == '0);
    assign o_status.slot_free  = slot_free;
    assign o_status.last_digit = (r_count == CNT_W'(1));

endmodule

// ===== src/signed_to_radix_digits.sv =====
// Flow: a check state follows the transfer in, then a sign state for a minus sign, then
// for each digit the shared divider passes over the value, STEPS bits per pass, and a push
// follows; then one result per cycle while the output is taken. The block takes one item
// at a time.
// Reset (synchronous, active low) sets radix 10 and symbols "0123456789" and idles the block.
module signed_to_radix_digits #(
    parameter int MAX_RADIX  = strd_pkg::MAX_RADIX_DEF,
    parameter int VALUE_BITS = strd_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [strd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [strd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [strd_pkg::SYM_W-1:0]   o_symbol,
    output logic                         o_is_last,
    output logic                         o_status
);
    import strd_pkg::*;

    t_cmd    cmd;
    t_status status;

    strd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    strd_dpath #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_symbol     (o_symbol),
        .o_is_last    (o_is_last),
        .o_status_bit (o_status)
    );

endmodule
